### hdl/mlpf_pkg.sv
// Shared types, constants and the tanh table entry function for the perceptron block.
package mlpf_pkg;

  localparam int unsigned INPUTS_DEF       = 11;
  localparam int unsigned HIDDEN_DEF       = 8;
  localparam int unsigned OUTPUTS_DEF      = 3;
  localparam int unsigned TANH_ENTRIES_DEF = 256;
  localparam int unsigned STORE_DEPTH      = 128;
  localparam int unsigned SLOT_W           = 7;
  localparam int unsigned VAL_W            = 16;
  localparam int unsigned SCORE_W          = 24;
  localparam int unsigned ACC_W            = 48;

  localparam logic KIND_WEIGHT  = 1'b0;
  localparam logic KIND_FEATURE = 1'b1;

  typedef enum logic [1:0] {OP_WEIGHT, OP_FEATURE, OP_INFER} op_t;

  // One queued command from the front end.
  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HBIAS, ST_HMAC, ST_HACT, ST_OBIAS, ST_OMAC, ST_OSAT, ST_SEND
  } state_t;

  // Table entry k approximates tanh(4k/entries) in Q11; built at elaboration.
  // step is 2^32 / entries.
  function automatic logic [VAL_W-1:0] tanh_entry(input longint unsigned step,
                                                  input int unsigned k);
    longint unsigned one;
    longint unsigned y;
    one = 64'd1 << 30;
    y = 0;
    for (int unsigned j = 0; j < k; j++) begin
      y = y + ((step * (one - ((y * y) >> 30))) >> 30);
      if (y > one) y = one;
    end
    return VAL_W'((y + (64'd1 << 18)) >> 19);
  endfunction

endpackage

### hdl/mlpf_front.sv
// Front end: accept items, classify them and push commands into a queue.
module mlpf_front
  import mlpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic              kind,
  input  logic [SLOT_W-1:0] slot,
  input  logic [VAL_W-1:0]  value,
  input  logic              last,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  localparam int unsigned QD = 4;
  localparam int unsigned QA = 2;

  cmd_t          q [QD];
  logic [QA-1:0] wr_ptr;
  logic [QA-1:0] rd_ptr;
  logic [QA:0]   count;
  logic          push;
  logic          pop;
  logic          infer;
  logic [QA:0]   need;

  // Final feature needs two entries: store, then infer.
  assign infer = (kind == KIND_FEATURE) && last;
  assign need  = infer ? (QA+1)'(2) : (QA+1)'(1);
  assign stall = (count + need) > (QA+1)'(QD);
  assign push  = valid && !stall;
  assign pop   = cmd_pop && (count != '0);
  assign cmd_valid = (count != '0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q[wr_ptr].op    <= (kind == KIND_WEIGHT) ? OP_WEIGHT : OP_FEATURE;
        q[wr_ptr].slot  <= slot;
        q[wr_ptr].value <= value;
        if (infer) begin
          q[wr_ptr + QA'(1)].op    <= OP_INFER;
          q[wr_ptr + QA'(1)].slot  <= slot;
          q[wr_ptr + QA'(1)].value <= value;
        end
        wr_ptr <= wr_ptr + (infer ? QA'(2) : QA'(1));
      end
      if (pop) rd_ptr <= rd_ptr + QA'(1);
      count <= count + (push ? need : '0) - (pop ? (QA+1)'(1) : '0);
    end
  end

endmodule

### hdl/mlpf_back.sv
// Back end: weight and feature stores plus a serial multiply-accumulate engine.
module mlpf_back
  import mlpf_pkg::*;
#(
  parameter int unsigned INPUTS       = INPUTS_DEF,
  parameter int unsigned HIDDEN       = HIDDEN_DEF,
  parameter int unsigned OUTPUTS      = OUTPUTS_DEF,
  parameter int unsigned TANH_ENTRIES = TANH_ENTRIES_DEF
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SCORE_W-1:0] score_left,
  output logic [SCORE_W-1:0] score_mid,
  output logic [SCORE_W-1:0] score_right,
  output logic [1:0]         best
);

  localparam int unsigned IW = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int unsigned HW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int unsigned TW = $clog2(TANH_ENTRIES);
  localparam int unsigned BASE_BH = INPUTS * HIDDEN;
  localparam int unsigned BASE_HO = BASE_BH + HIDDEN;
  localparam int unsigned BASE_BO = BASE_HO + HIDDEN * OUTPUTS;
  localparam longint unsigned TANH_STEP = (64'd1 << 32) / TANH_ENTRIES;

  function automatic logic [TANH_ENTRIES-1:0][VAL_W-1:0] build_table();
    logic [TANH_ENTRIES-1:0][VAL_W-1:0] t;
    for (int unsigned k = 0; k < TANH_ENTRIES; k++) t[k] = tanh_entry(TANH_STEP, k);
    return t;
  endfunction

  localparam logic [TANH_ENTRIES-1:0][VAL_W-1:0] TANH_TABLE = build_table();

  logic [VAL_W-1:0] wmem [STORE_DEPTH];
  logic [VAL_W-1:0] rdata;
  logic [SLOT_W-1:0] raddr;
  logic             rd_en;
  logic [VAL_W-1:0] feat [INPUTS];
  logic [VAL_W-1:0] hid  [HIDDEN];

  state_t state, state_next;
  logic [IW-1:0] i_cnt, i_cnt_next;
  logic [HW-1:0] h_cnt, h_cnt_next;
  logic [1:0]    o_cnt, o_cnt_next;
  logic          mul_v;            // rdata valid for a product this cycle
  logic          mul_v_next;
  logic          bias_v, bias_v_next;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]      prod;
  logic                    prod_v;
  logic signed [VAL_W-1:0] mul_a;
  logic signed [ACC_W-1:0] fl;
  logic signed [SCORE_W-1:0] sat;
  logic signed [SCORE_W-1:0] scores [3];
  logic [1:0]    bidx;
  logic signed [VAL_W-1:0] th;
  logic [ACC_W-1:0] mag;
  logic [TW-1:0]  tidx;
  logic [VAL_W-1:0] tval;
  logic signed [SCORE_W-1:0] cand;

  assign fl = acc >>> 11;

  // tanh lookup on floor(acc)
  always_comb begin
    mag  = fl[ACC_W-1] ? ACC_W'(-fl) : ACC_W'(fl);
    tidx = TW'((mag * ACC_W'(TANH_ENTRIES)) >> 13);
    tval = (mag >= ACC_W'(8192)) ? VAL_W'(2047) : TANH_TABLE[tidx];
    th   = fl[ACC_W-1] ? -$signed(tval) : $signed(tval);
  end

  always_comb begin
    if (fl > ACC_W'(signed'(SCORE_W'(8388607))) ) sat = 24'sh7fffff;
    else if (fl < -ACC_W'(48'sd8388608)) sat = 24'sh800000;
    else sat = SCORE_W'(fl);
  end

  // current leader among the scores already latched
  assign cand = (bidx == 2'd0) ? scores[0] : (bidx == 2'd1) ? scores[1] : scores[2];

  always_comb begin
    state_next = state;
    i_cnt_next = i_cnt;
    h_cnt_next = h_cnt;
    o_cnt_next = o_cnt;
    mul_v_next = 1'b0;
    bias_v_next = 1'b0;
    cmd_pop = 1'b0;
    rd_en = 1'b0;
    raddr = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_INFER) begin
            h_cnt_next = '0;
            state_next = ST_HBIAS;
          end
        end
      end
      ST_HBIAS: begin
        rd_en = 1'b1;
        raddr = SLOT_W'(BASE_BH + h_cnt);
        bias_v_next = 1'b1;
        i_cnt_next = '0;
        state_next = ST_HMAC;
      end
      ST_HMAC: begin
        rd_en = 1'b1;
        raddr = SLOT_W'(i_cnt * HIDDEN + h_cnt);
        mul_v_next = 1'b1;
        if (i_cnt == IW'(INPUTS - 1)) state_next = ST_HACT;
        else i_cnt_next = i_cnt + IW'(1);
      end
      ST_HACT: begin
        // wait for the pipeline to drain, then latch activation
        if (!mul_v && !prod_v) begin
          if (h_cnt == HW'(HIDDEN - 1)) begin
            o_cnt_next = '0;
            state_next = ST_OBIAS;
          end else begin
            h_cnt_next = h_cnt + HW'(1);
            state_next = ST_HBIAS;
          end
        end
      end
      ST_OBIAS: begin
        rd_en = 1'b1;
        raddr = SLOT_W'(BASE_BO + o_cnt);
        bias_v_next = 1'b1;
        h_cnt_next = '0;
        state_next = ST_OMAC;
      end
      ST_OMAC: begin
        rd_en = 1'b1;
        raddr = SLOT_W'(BASE_HO + h_cnt * OUTPUTS + o_cnt);
        mul_v_next = 1'b1;
        if (h_cnt == HW'(HIDDEN - 1)) state_next = ST_OSAT;
        else h_cnt_next = h_cnt + HW'(1);
      end
      ST_OSAT: begin
        if (!mul_v && !prod_v) begin
          if (o_cnt == 2'(OUTPUTS - 1)) state_next = ST_SEND;
          else begin
            o_cnt_next = o_cnt + 2'd1;
            state_next = ST_OBIAS;
          end
        end
      end
      ST_SEND: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // operand for multiplier: feature for hidden layer, activation for output layer
  logic [IW-1:0] i_d;
  logic [HW-1:0] h_d;
  logic          out_layer_d;
  assign mul_a = out_layer_d ? $signed(hid[h_d]) : $signed(feat[i_d]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      i_cnt  <= '0;
      h_cnt  <= '0;
      o_cnt  <= '0;
      mul_v  <= 1'b0;
      bias_v <= 1'b0;
      prod_v <= 1'b0;
      bidx   <= '0;
    end else begin
      state  <= state_next;
      i_cnt  <= i_cnt_next;
      h_cnt  <= h_cnt_next;
      o_cnt  <= o_cnt_next;
      mul_v  <= mul_v_next;
      bias_v <= bias_v_next;
      prod_v <= mul_v;
      if (state == ST_OSAT && !mul_v && !prod_v) begin
        if (o_cnt == 2'd0) bidx <= 2'd0;
        else if (sat > cand) bidx <= o_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_WEIGHT) wmem[cmd.slot] <= cmd.value;
    if (rd_en) rdata <= wmem[raddr];
    if (cmd_pop && cmd.op == OP_FEATURE && cmd.slot < SLOT_W'(INPUTS))
      feat[IW'(cmd.slot)] <= cmd.value;
    i_d <= i_cnt;
    h_d <= h_cnt;
    out_layer_d <= (state == ST_OMAC);
    if (mul_v) prod <= mul_a * $signed(rdata);
    if (bias_v) acc <= ACC_W'($signed(rdata)) <<< 11;
    else if (prod_v) acc <= acc + ACC_W'(prod);
    if (state == ST_HACT && !mul_v && !prod_v) hid[h_cnt] <= th;
    if (state == ST_OSAT && !mul_v && !prod_v) begin
      if (o_cnt == 2'd0) scores[0] <= sat;
      if (o_cnt == 2'd1) scores[1] <= sat;
      if (o_cnt == 2'd2) scores[2] <= sat;
    end
    if (state == ST_IDLE && cmd_pop && cmd.op == OP_INFER) begin
      scores[0] <= '0;
      scores[1] <= '0;
      scores[2] <= '0;
    end
  end

  assign out_valid   = (state == ST_SEND);
  assign score_left  = scores[0];
  assign score_mid   = scores[1];
  assign score_right = scores[2];
  assign best        = bidx;

endmodule

### hdl/mlp_forward_tanh_top.sv
// Two-layer tanh perceptron: weight/feature input channel and score result channel.
//
// Input channel (valid/stall): kind 0 writes value to weight word slot;
// kind 1 stores value as feature slot, and with last set starts inference.
// Output channel (valid/stall): three saturated Q11 scores and argmax best.
// A front end classifies items into a four-entry command queue; the back end
// runs one serial multiply-accumulate per cycle from the single-port weight
// store, so weight and plain feature items drain from the queue while it is idle.
// After the final feature's transfer, the hidden and then the output layer run
// in turn on the one shared multiplier (bias, products, then activation or
// saturation per neuron); the back end returns to idle once the result is taken.
// Input keeps flowing into the queue during inference until it fills.
// Reset clears the queue and sequencer; stores hold garbage until written.
// While the receiver stalls, the result holds steady and the back end waits.
module mlp_forward_tanh_top
  import mlpf_pkg::*;
#(
  parameter int unsigned INPUTS       = INPUTS_DEF,
  parameter int unsigned HIDDEN       = HIDDEN_DEF,
  parameter int unsigned OUTPUTS      = OUTPUTS_DEF,
  parameter int unsigned TANH_ENTRIES = TANH_ENTRIES_DEF
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [VAL_W-1:0]   value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SCORE_W-1:0] score_left,
  output logic [SCORE_W-1:0] score_mid,
  output logic [SCORE_W-1:0] score_right,
  output logic [1:0]         best
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  mlpf_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .kind, .slot, .value, .last,
    .cmd_valid, .cmd, .cmd_pop
  );

  mlpf_back #(
    .INPUTS(INPUTS), .HIDDEN(HIDDEN), .OUTPUTS(OUTPUTS), .TANH_ENTRIES(TANH_ENTRIES)
  ) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop, .out_valid, .out_stall,
    .score_left, .score_mid, .score_right, .best
  );

endmodule

### test/tb_top.sv
// Self-checking testbench for the two-layer tanh perceptron block.
`timescale 1ns / 1ps
module tb_top;
  import mlpf_pkg::*;

  localparam int NIN     = 11;
  localparam int NHID    = 8;
  localparam int NOUT    = 3;
  localparam int NTANH   = 256;
  localparam int HBIAS_AT = NIN * NHID;
  localparam int HO_AT    = HBIAS_AT + NHID;
  localparam int OBIAS_AT = HO_AT + NHID * NOUT;
  localparam int LIMIT    = 1500000;
  localparam int SCORE_HI = 8388607;
  localparam int SCORE_LO = -8388608;

  typedef struct {
    logic [SCORE_W-1:0] left, mid, right;
    logic [1:0]         idx;
  } scores_t;

  typedef struct {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  value;
    logic              last;
    bit                typed;
    int                left, mid, right, idx;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, kind = 0, last = 0, out_stall = 0;
  logic [SLOT_W-1:0] slot = '0;
  logic [VAL_W-1:0] value = '0;
  logic in_stall, out_valid;
  logic [SCORE_W-1:0] score_left, score_mid, score_right;
  logic [1:0] best;

  shortint genome[STORE_DEPTH];
  shortint features[NIN];
  shortint hidden[NHID];
  shortint squash_tbl[NTANH];
  scores_t pending_scores[$];
  int errors = 0, cycles = 0, hold_cycles = 0;
  bit quiet = 0;
  bit held = 0, drained = 0;
  row_t dir_rows[$];

  mlp_forward_tanh_top dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int squash(longint x);
    longint mag;
    int r;
    mag = x < 0 ? -x : x;
    if (mag >= 8192) r = 2047;
    else r = squash_tbl[(mag * NTANH) >> 13];
    return x < 0 ? -r : r;
  endfunction

  // Update the model state for one transfer; return 1 when a result is due.
  function automatic bit infer_step(logic k, logic [SLOT_W-1:0] s, logic [VAL_W-1:0] v,
                                    logic l, output scores_t res);
    longint acc, sc[3];
    int b;
    res = '{default: '0};
    if (k == KIND_WEIGHT) begin
      genome[s] = v;
      return 0;
    end
    if (s < NIN) features[s] = v;
    if (!l) return 0;
    for (int h = 0; h < NHID; h++) begin
      acc = longint'(genome[HBIAS_AT + h]) * 2048;
      for (int i = 0; i < NIN; i++)
        acc += longint'(features[i]) * longint'(genome[i * NHID + h]);
      hidden[h] = shortint'(squash(acc >>> 11));
    end
    b = 0;
    for (int o = 0; o < NOUT; o++) begin
      acc = longint'(genome[OBIAS_AT + o]) * 2048;
      for (int h = 0; h < NHID; h++)
        acc += longint'(hidden[h]) * longint'(genome[HO_AT + h * NOUT + o]);
      acc = acc >>> 11;
      if (acc > SCORE_HI) acc = SCORE_HI;
      if (acc < SCORE_LO) acc = SCORE_LO;
      sc[o] = acc;
      if (o > 0 && acc > sc[b]) b = o;
    end
    res.left = sc[0][SCORE_W-1:0];
    res.mid = sc[1][SCORE_W-1:0];
    res.right = sc[2][SCORE_W-1:0];
    res.idx = b[1:0];
    return 1;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return VAL_W'($urandom);
      3:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      4, 5:    return VAL_W'($urandom_range(0, 8191) - 4096);
      default: return VAL_W'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  function automatic int rand_gap();
    if (quiet) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 0;
      6, 7, 8:          return $urandom_range(1, 3);
      default:          return $urandom_range(5, 40);
    endcase
  endfunction

  // Drive one transfer and hold it until accepted.
  task automatic send(logic k, logic [SLOT_W-1:0] s, logic [VAL_W-1:0] v, logic l,
                      bit typed = 0, scores_t typed_res = '{default: '0});
    scores_t res;
    int gap;
    if (infer_step(k, s, v, l, res)) pending_scores.push_back(typed ? typed_res : res);
    in_valid <= 1;
    kind <= k;
    slot <= s;
    value <= v;
    last <= l;
    do @(posedge clk); while (in_stall);
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stall, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 9) < 3);
    end
  end

  always @(posedge clk) begin
    scores_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h %h %0d",
                                   score_left, score_mid, score_right, best);
      end else begin
        e = pending_scores.pop_front();
        if (e.left !== score_left || e.mid !== score_mid || e.right !== score_right ||
            e.idx !== best) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h %h %h %0d got %h %h %h %0d", e.left, e.mid, e.right,
                     e.idx, score_left, score_mid, score_right, best);
        end
      end
    end
  end

  task automatic add_row(logic k, int s, int v, logic l, bit typed = 0,
                         int a = 0, int m = 0, int r = 0, int b = 0);
    row_t row;
    row = '{k, SLOT_W'(s), VAL_W'(v), l, typed, a, m, r, b};
    dir_rows.push_back(row);
  endtask

  initial begin
    longint unsigned one, step, y;
    scores_t tr;
    int order[NIN];
    int n, t, sent;
    one = 64'd1 << 30;
    step = (64'd1 << 32) / NTANH;
    y = 0;
    for (int k = 0; k < NTANH; k++) begin
      squash_tbl[k] = shortint'((y + (64'd1 << 18)) >> 19);
      y = y + ((step * (one - ((y * y) >> 30))) >> 30);
      if (y > one) y = one;
    end

    repeat (11) @(posedge clk);
    rst <= 0;

    // Zero genome, then a handful of cases whose scores are plain to see.
    for (int s = 0; s < STORE_DEPTH; s++) send(KIND_WEIGHT, SLOT_W'(s), '0, 1'b0);
    add_row(KIND_FEATURE, 0, 32767, 1'b0);
    add_row(KIND_FEATURE, 1, -32768, 1'b0);
    for (int i = 2; i < NIN - 1; i++) add_row(KIND_FEATURE, i, i * 1000 - 5000, 1'b0);
    add_row(KIND_FEATURE, NIN - 1, 32767, 1'b1, 1'b1, 0, 0, 0, 0);
    add_row(KIND_WEIGHT, OBIAS_AT, 32767, 1'b0);
    add_row(KIND_FEATURE, 127, -1, 1'b1, 1'b1, 32767, 0, 0, 0);
    add_row(KIND_WEIGHT, OBIAS_AT + 1, -32768, 1'b1);
    add_row(KIND_WEIGHT, OBIAS_AT + 2, 32767, 1'b0);
    add_row(KIND_FEATURE, NIN, 5, 1'b1, 1'b1, 32767, -32768, 32767, 0);
    add_row(KIND_WEIGHT, OBIAS_AT, -1, 1'b0);
    add_row(KIND_FEATURE, 3, 12, 1'b1, 1'b1, -1, -32768, 32767, 2);
    add_row(KIND_WEIGHT, HBIAS_AT, 32767, 1'b0);
    add_row(KIND_WEIGHT, HO_AT, 32767, 1'b0);
    add_row(KIND_FEATURE, 0, -32768, 1'b1);
    foreach (dir_rows[j]) begin
      tr.left = SCORE_W'(dir_rows[j].left);
      tr.mid = SCORE_W'(dir_rows[j].mid);
      tr.right = SCORE_W'(dir_rows[j].right);
      tr.idx = 2'(dir_rows[j].idx);
      send(dir_rows[j].kind, dir_rows[j].slot, dir_rows[j].value, dir_rows[j].last,
           dir_rows[j].typed, tr);
    end

    sent = 0;
    while (sent < 1800) begin
      if ($urandom_range(0, 19) == 0) begin
        quiet = 1;
        for (int s = 0; s < STORE_DEPTH; s++)
          send(KIND_WEIGHT, SLOT_W'(s), rand_value(), 1'b0);
        sent += STORE_DEPTH;
      end else if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 10);
        for (int j = 0; j < n; j++)
          send(KIND_WEIGHT, SLOT_W'($urandom_range(0, 127)), rand_value(),
               $urandom_range(0, 5) == 0);
        sent += n;
      end
      quiet = ($urandom_range(0, 7) == 0);
      if (!held && sent > 600) begin
        held = 1;
        hold_cycles = 600;
      end
      if (!drained && sent > 1200) begin
        drained = 1;
        wait (pending_scores.size() == 0);
      end
      for (int i = 0; i < NIN; i++) order[i] = i;
      order.shuffle();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NIN) : NIN;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0)
          send(KIND_FEATURE, SLOT_W'($urandom_range(NIN, 127)), rand_value(), 1'b0);
        send(KIND_FEATURE, SLOT_W'(order[i]), rand_value(), i == n - 1);
      end
      sent += n;
    end

    in_valid <= 0;
    quiet = 1;
    t = 0;
    while (pending_scores.size() != 0 && t < 20000) begin
      @(posedge clk);
      t++;
    end
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_scores.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### sim.f
hdl/mlpf_pkg.sv
hdl/mlpf_front.sv
hdl/mlpf_back.sv
hdl/mlp_forward_tanh_top.sv
test/tb_top.sv
